@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the rcap rtl files
// no dependencies; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rcap assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcap assertion failed");

`endif

@@ rtl/core/rcap_pkg.sv @@
// shared types and constants of the resp command array parser
// no dependencies; imported by rcap_parse_core and resp_command_array_parser
`timescale 1ns / 1ps

package rcap_pkg;

   // counter widths
   localparam int COUNT_BITS  = 16;
   localparam int LENGTH_BITS = 32;
   localparam int LIMIT_BITS  = 8;
   localparam int WIDE_BITS   = LENGTH_BITS + 4;

   // largest legal count and length, at the width of acc * 10 + digit
   localparam logic [WIDE_BITS-1:0] COUNT_MAX  = (WIDE_BITS'(1) << COUNT_BITS) - WIDE_BITS'(1);
   localparam logic [WIDE_BITS-1:0] LENGTH_MAX = (WIDE_BITS'(1) << LENGTH_BITS) - WIDE_BITS'(1);

   // characters of the protocol
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(32);

   // per-byte event codes
   typedef enum logic [2:0] {
      EV_FRAME     = 3'd0,
      EV_NAME_KEEP = 3'd1,
      EV_NAME_DROP = 3'd2,
      EV_ARG       = 3'd3,
      EV_ELEM_DONE = 3'd4,
      EV_CMD_DONE  = 3'd5,
      EV_ERROR     = 3'd6
   } event_type;

   // error codes
   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_NOT_ARRAY  = 3'd1,
      ERR_BAD_DIGIT  = 3'd2,
      ERR_MISSING_LF = 3'd3,
      ERR_EMPTY      = 3'd4,
      ERR_NOT_BULK   = 3'd5,
      ERR_TRAILER    = 3'd6,
      ERR_OVERFLOW   = 3'd7
   } error_type;

   // one result transaction
   typedef struct packed {
      event_type              event_res;
      logic [7:0]             payload_byte;
      logic [COUNT_BITS-1:0]  element_index;
      logic [LENGTH_BITS-1:0] element_length;
      logic [COUNT_BITS-1:0]  argument_count;
      error_type              error_code;
   } result_type;

endpackage

@@ rtl/core/rcap_parse_core.sv @@
// parse state and per-byte classification of the resp command parser
// depends on rcap_pkg and assert_macros.svh
`timescale 1ns / 1ps

module rcap_parse_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step_en,
   input  logic [7:0]                     data_byte,
   input  logic [rcap_pkg::LIMIT_BITS-1:0] name_keep_limit,
   output rcap_pkg::result_type           result
);
   import rcap_pkg::*;

   `include "assert_macros.svh"

   typedef enum logic [3:0] {
      PH_WAIT     = 4'd0,
      PH_COUNT    = 4'd1,
      PH_COUNT_LF = 4'd2,
      PH_BTYPE    = 4'd3,
      PH_BLEN     = 4'd4,
      PH_BLEN_LF  = 4'd5,
      PH_DATA     = 4'd6,
      PH_TCR      = 4'd7,
      PH_TLF      = 4'd8,
      PH_RESYNC   = 4'd9
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [COUNT_BITS-1:0]  elems_left_ff, elems_left_in;
   logic [LENGTH_BITS-1:0] acc_ff, acc_in;
   logic [LENGTH_BITS-1:0] pay_left_ff, pay_left_in;
   logic [LIMIT_BITS-1:0]  keep_left_ff, keep_left_in;
   logic [COUNT_BITS-1:0]  cur_elem_ff, cur_elem_in;
   logic [COUNT_BITS-1:0]  total_args_ff, total_args_in;

   logic                   is_digit;
   logic [WIDE_BITS-1:0]   acc_wide;
   logic                   acc_over;
   logic [LIMIT_BITS-1:0]  limit_eff;
   logic [LENGTH_BITS-1:0] pay_left_dec;
   event_type              ev;
   error_type              err;
   logic [7:0]             pay;

   // decimal digit accumulate: acc * 10 + digit
   assign is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
   assign acc_wide = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1)
                   + {{(WIDE_BITS-4){1'b0}}, data_byte[3:0]};
   assign acc_over = (phase_ff == PH_COUNT) ? (acc_wide > COUNT_MAX)
                                            : (acc_wide > LENGTH_MAX);
   assign limit_eff    = (name_keep_limit == '0) ? LIMIT_BITS'(1) : name_keep_limit;
   assign pay_left_dec = pay_left_ff - LENGTH_BITS'(1);

   // next state and classification of the current byte
   always_comb begin
      phase_in      = phase_ff;
      elems_left_in = elems_left_ff;
      acc_in        = acc_ff;
      pay_left_in   = pay_left_ff;
      keep_left_in  = keep_left_ff;
      cur_elem_in   = cur_elem_ff;
      total_args_in = total_args_ff;
      ev            = EV_FRAME;
      err           = ERR_NONE;
      pay           = 8'd0;
      unique case (phase_ff)
         PH_WAIT, PH_RESYNC: begin
            if (data_byte == CHAR_STAR) begin
               phase_in      = PH_COUNT;
               acc_in        = '0;
               elems_left_in = '0;
               cur_elem_in   = '0;
               total_args_in = '0;
            end else if (phase_ff == PH_WAIT) begin
               err = ERR_NOT_ARRAY;
            end
         end
         PH_COUNT, PH_BLEN: begin
            if (is_digit) begin
               if (acc_over) err = ERR_OVERFLOW;
               else acc_in = acc_wide[LENGTH_BITS-1:0];
            end else if (data_byte == CHAR_CR) begin
               phase_in = (phase_ff == PH_COUNT) ? PH_COUNT_LF : PH_BLEN_LF;
            end else begin
               err = ERR_BAD_DIGIT;
            end
         end
         PH_COUNT_LF: begin
            if (data_byte != CHAR_LF) begin
               err = ERR_MISSING_LF;
            end else if (acc_ff == '0) begin
               err = ERR_EMPTY;
            end else begin
               elems_left_in = acc_ff[COUNT_BITS-1:0];
               total_args_in = acc_ff[COUNT_BITS-1:0] - COUNT_BITS'(1);
               cur_elem_in   = '0;
               phase_in      = PH_BTYPE;
            end
         end
         PH_BTYPE: begin
            if (data_byte == CHAR_DOLLAR) begin
               acc_in   = '0;
               phase_in = PH_BLEN;
            end else begin
               err = ERR_NOT_BULK;
            end
         end
         PH_BLEN_LF: begin
            if (data_byte != CHAR_LF) begin
               err = ERR_MISSING_LF;
            end else begin
               pay_left_in = acc_ff;
               if (cur_elem_ff == '0) begin
                  // long names keep one byte less than the limit
                  if (acc_ff > {{(LENGTH_BITS-LIMIT_BITS){1'b0}}, limit_eff})
                     keep_left_in = limit_eff - LIMIT_BITS'(1);
                  else
                     keep_left_in = acc_ff[LIMIT_BITS-1:0];
               end
               phase_in = (acc_ff != '0) ? PH_DATA : PH_TCR;
            end
         end
         PH_DATA: begin
            pay = data_byte;
            if (cur_elem_ff == '0) begin
               if (keep_left_ff != '0) begin
                  ev           = EV_NAME_KEEP;
                  keep_left_in = keep_left_ff - LIMIT_BITS'(1);
               end else begin
                  ev = EV_NAME_DROP;
               end
            end else begin
               ev = EV_ARG;
            end
            pay_left_in = pay_left_dec;
            if (pay_left_dec == '0) phase_in = PH_TCR;
         end
         PH_TCR: begin
            if (data_byte == CHAR_CR) phase_in = PH_TLF;
            else err = ERR_TRAILER;
         end
         PH_TLF: begin
            if (data_byte != CHAR_LF) begin
               err = ERR_TRAILER;
            end else begin
               elems_left_in = elems_left_ff - COUNT_BITS'(1);
               if (elems_left_ff == COUNT_BITS'(1)) begin
                  ev       = EV_CMD_DONE;
                  phase_in = PH_WAIT;
               end else begin
                  ev          = EV_ELEM_DONE;
                  cur_elem_in = cur_elem_ff + COUNT_BITS'(1);
                  phase_in    = PH_BTYPE;
               end
            end
         end
         default: phase_in = PH_RESYNC;
      endcase
      // any error drops to resync
      if (err != ERR_NONE) begin
         ev       = EV_ERROR;
         pay      = 8'd0;
         phase_in = PH_RESYNC;
      end
   end

   // result fields from the updated state
   always_comb begin
      result.event_res      = ev;
      result.payload_byte   = pay;
      result.element_index  = cur_elem_in;
      result.element_length = (phase_ff >= PH_BLEN && phase_ff <= PH_TLF) ? acc_in : '0;
      result.argument_count = total_args_in;
      result.error_code     = err;
   end

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_WAIT;
         elems_left_ff <= '0;
         acc_ff        <= '0;
         pay_left_ff   <= '0;
         keep_left_ff  <= '0;
         cur_elem_ff   <= '0;
         total_args_ff <= '0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         elems_left_ff <= elems_left_in;
         acc_ff        <= acc_in;
         pay_left_ff   <= pay_left_in;
         keep_left_ff  <= keep_left_in;
         cur_elem_ff   <= cur_elem_in;
         total_args_ff <= total_args_in;
      end
   end

   // an error always leaves the parser resynchronizing
   `ASSERT_NEXT(a_err_resync, clock, reset, step_en && (err != ERR_NONE), phase_ff == PH_RESYNC)
   // a payload byte is only ever seen with a nonzero remaining length
   `ASSERT_IMPLY(a_data_len, clock, reset, step_en && (phase_ff == PH_DATA), pay_left_ff != '0)

endmodule

@@ rtl/core/resp_command_array_parser.sv @@
// top level of the resp command array parser: input, output and csr registers
// depends on rcap_pkg, rcap_parse_core and assert_macros.svh
`timescale 1ns / 1ps
//
// channel  direction  handshake            payload
// req_     in         req_valid/req_ready  req_data_byte
// rsp_     out        rsp_valid/rsp_ready  event, byte, index, length, count, error
// csr_     in         csr_wr_en            csr_wr_data (name keep limit)
//
// one byte per clock sustained while rsp_ready stays high; each byte produces exactly one result
// a byte passes the input register, then the parse step into the result register
// the parse step is one pass of the digit accumulate (acc * 10 + digit) and compare
// a stalled rsp_ready holds the pipeline; the input register still takes one byte
// synchronous active-high reset returns to waiting for '*', name limit 32

module resp_command_array_parser (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_data_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [2:0]                       rsp_event_res,
   output logic [7:0]                       rsp_payload_byte,
   output logic [rcap_pkg::COUNT_BITS-1:0]  rsp_element_index,
   output logic [rcap_pkg::LENGTH_BITS-1:0] rsp_element_length,
   output logic [rcap_pkg::COUNT_BITS-1:0]  rsp_argument_count,
   output logic [2:0]                       rsp_error_code,
   input  logic                             csr_wr_en,
   input  logic [rcap_pkg::LIMIT_BITS-1:0]  csr_wr_data
);
   import rcap_pkg::*;

   `include "assert_macros.svh"

   logic                  in_vld_ff;
   logic [7:0]            in_byte_ff;
   logic                  out_vld_ff;
   result_type            out_ff;
   result_type            step_res;
   logic [LIMIT_BITS-1:0] limit_ff;
   logic                  advance;

   // the held byte moves on when the result register is free or draining
   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;

   // name keep limit register
   always_ff @(posedge clock) begin
      if (reset) limit_ff <= LIMIT_RESET;
      else if (csr_wr_en) limit_ff <= csr_wr_data;
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
      if (req_ready && req_valid) in_byte_ff <= req_data_byte;
   end

   rcap_parse_core u_core (
      .clock           (clock),
      .reset           (reset),
      .step_en         (advance),
      .data_byte       (in_byte_ff),
      .name_keep_limit (limit_ff),
      .result          (step_res)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_vld_ff <= 1'b0;
      end
      if (advance) out_ff <= step_res;
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_event_res      = out_ff.event_res;
   assign rsp_payload_byte   = out_ff.payload_byte;
   assign rsp_element_index  = out_ff.element_index;
   assign rsp_element_length = out_ff.element_length;
   assign rsp_argument_count = out_ff.argument_count;
   assign rsp_error_code     = out_ff.error_code;

   // error code travels with the error event and only with it
   `ASSERT_IMPLY(a_err_code, clock, reset, out_vld_ff, (out_ff.event_res == EV_ERROR) == (out_ff.error_code != ERR_NONE))
   // a held byte is not lost while the result side stalls
   `ASSERT_NEXT(a_in_hold, clock, reset, in_vld_ff && !advance, in_vld_ff && $stable(in_byte_ff))

endmodule
